// ===== hw/rtl/rrrb_pkg.sv =====
// Shared types and codes for the receive reorder buffer.
`default_nettype none

package rrrb_pkg;

  // Result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_DELIVER = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // Acknowledge status codes
  localparam logic [1:0] ST_IN_ORDER    = 2'd0;
  localparam logic [1:0] ST_DUPLICATE   = 2'd1;
  localparam logic [1:0] ST_BUFFERED    = 2'd2;
  localparam logic [1:0] ST_ALREADY_BUF = 2'd3;

  localparam int unsigned SEQ_W = 16;
  localparam int unsigned TAG_W = 16;

  typedef struct packed {
    logic             is_reliable;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] payload_tag;
  } pkt_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [SEQ_W-1:0] out_seq;
    logic [TAG_W-1:0] out_tag;
    logic             last;
  } res_t;

  // Request to and response from the shared adder
  typedef struct packed {
    logic             sub;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [SEQ_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrrb_alu.sv =====
// Shared 16-bit adder/subtractor used for distance, slot index, reduction and drain steps.
`default_nettype none

module rrrb_alu (
  input  rrrb_pkg::alu_req_t req_i,
  output rrrb_pkg::alu_rsp_t rsp_o
);
  import rrrb_pkg::*;

  logic [SEQ_W:0] full;

  // Add, or add the complement plus one; carry set means no borrow on subtract
  always_comb begin
    full = {1'b0, req_i.a} + {1'b0, (req_i.sub ? ~req_i.b : req_i.b)}
         + {{SEQ_W{1'b0}}, req_i.sub};
    rsp_o.sum   = full[SEQ_W-1:0];
    rsp_o.carry = full[SEQ_W];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rrrb_slot_store.sv =====
// Slot valid flags and payload tag memory of the reorder window.
`default_nettype none

module rrrb_slot_store #(
  parameter int unsigned WINDOW = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               set_i,
  input  wire                               clr_i,
  input  wire  [$clog2(WINDOW)-1:0]         addr_i,
  input  wire  [rrrb_pkg::TAG_W-1:0]        wdata_i,
  input  wire                               rd_en_i,
  input  wire  [$clog2(WINDOW)-1:0]         rd_addr_i,
  output logic [rrrb_pkg::TAG_W-1:0]        rdata_o,
  output logic [WINDOW-1:0]                 valid_o
);
  import rrrb_pkg::*;

  logic [WINDOW-1:0] valid_q;
  logic [TAG_W-1:0]  tag_mem [WINDOW];

  // Set a slot on store, drop it on delivery
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (set_i) begin
      valid_q[addr_i] <= 1'b1;
    end else if (clr_i) begin
      valid_q[addr_i] <= 1'b0;
    end
  end

  // Write the tag of a stored packet
  always_ff @(posedge clk_i) begin
    if (set_i) begin
      tag_mem[addr_i] <= wdata_i;
    end
  end

  // Registered read for the drain
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_o <= tag_mem[rd_addr_i];
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/reliable_receive_reorder_buffer.sv =====
// Receive reorder buffer: sequencer around one shared adder and the slot store.
// Unreliable packet: one result in the cycle after acceptance, busy stays low.
// Old or beyond-window packet: busy 1 cycle, result registered from the distance step.
// In-order packet: ack registered from the distance step, then its delivery and one buffered slot
// per cycle; busy until the last delivery. Window store: busy during its adder steps.
// Results cannot be held off. Reset clears all slot flags at once and sets last to 65535.
`default_nettype none

module reliable_receive_reorder_buffer #(
  parameter int unsigned WINDOW = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  input  rrrb_pkg::pkt_t       in_i,
  output logic                 busy,
  output logic                 res_valid_o,
  output rrrb_pkg::res_t       res_o
);
  import rrrb_pkg::*;

  localparam int unsigned IXW = $clog2(WINDOW);
  localparam int unsigned TW  = $clog2(3 * WINDOW);

  localparam logic [IXW-1:0]   LdIxReset = IXW'(65535 % WINDOW);
  localparam logic [IXW-1:0]   IxMax     = IXW'(WINDOW - 1);
  localparam logic [IXW-1:0]   CntMax    = IXW'(WINDOW - 2);
  localparam logic [SEQ_W-1:0] WinW      = SEQ_W'(WINDOW);
  localparam logic [SEQ_W-1:0] WrapAdj   = SEQ_W'(WINDOW - (65536 % WINDOW));

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIST = 3'd1;
  localparam logic [2:0] S_IX1  = 3'd2;
  localparam logic [2:0] S_IX2  = 3'd3;
  localparam logic [2:0] S_RED  = 3'd4;
  localparam logic [2:0] S_DLV  = 3'd5;
  localparam logic [2:0] S_DRN  = 3'd6;

  logic [2:0]       state_q, state_d;
  pkt_t             pkt_q, pkt_d;
  logic [SEQ_W-1:0] ld_q, ld_d;
  logic [IXW-1:0]   ldix_q, ldix_d;
  logic [TW-1:0]    d_q, d_d;
  logic             wrap_q, wrap_d;
  logic [TW-1:0]    t_q, t_d;
  logic [IXW-1:0]   cnt_q, cnt_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  logic             slot_set, slot_clr, slot_rd;
  logic [IXW-1:0]   slot_addr, slot_rd_addr;
  logic [TAG_W-1:0] slot_rdata;
  logic [WINDOW-1:0] slot_valid;

  logic [IXW-1:0]   cur_ix, nix;
  logic             nvalid, lastf;

  // Slot index of the number after s, given the slot index of s
  function automatic logic [IXW-1:0] ix_next(input logic [IXW-1:0] ix,
                                             input logic [SEQ_W-1:0] s);
    logic [IXW-1:0] r;
    if (s == {SEQ_W{1'b1}}) begin
      r = '0;
    end else if (ix == IxMax) begin
      r = '0;
    end else begin
      r = ix + 1'b1;
    end
    return r;
  endfunction

  rrrb_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  rrrb_slot_store #(
    .WINDOW (WINDOW)
  ) u_slots (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .set_i     (slot_set),
    .clr_i     (slot_clr),
    .addr_i    (slot_addr),
    .wdata_i   (pkt_q.payload_tag),
    .rd_en_i   (slot_rd),
    .rd_addr_i (slot_rd_addr),
    .rdata_o   (slot_rdata),
    .valid_o   (slot_valid)
  );

  // Slot of the next expected number
  assign cur_ix = ix_next(ldix_q, ld_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    pkt_d        = pkt_q;
    ld_d         = ld_q;
    ldix_d       = ldix_q;
    d_d          = d_q;
    wrap_d       = wrap_q;
    t_d          = t_q;
    cnt_d        = cnt_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    alu_req      = '0;
    slot_set     = 1'b0;
    slot_clr     = 1'b0;
    slot_addr    = cur_ix;
    slot_rd      = 1'b0;
    slot_rd_addr = cur_ix;
    nix          = cur_ix;
    nvalid       = 1'b0;
    lastf        = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          pkt_d = in_i;
          if (in_i.is_reliable) begin
            state_d = S_DIST;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{KIND_DELIVER, ST_IN_ORDER, '0, in_i.payload_tag, 1'b1};
          end
        end
      end

      S_DIST: begin
        // Distance from the last delivered number, borrow marks a wrap
        alu_req = '{1'b1, pkt_q.seq, ld_q};
        wrap_d  = ~alu_rsp.carry;
        if (alu_rsp.sum == '0 || alu_rsp.sum[SEQ_W-1]) begin
          res_valid_d = 1'b1;
          res_d       = '{KIND_ACK, ST_DUPLICATE, pkt_q.seq, '0, 1'b1};
          state_d     = S_IDLE;
        end else if (alu_rsp.sum == SEQ_W'(1)) begin
          res_valid_d = 1'b1;
          res_d       = '{KIND_ACK, ST_IN_ORDER, pkt_q.seq, '0, 1'b0};
          state_d     = S_DLV;
        end else if (alu_rsp.sum <= WinW) begin
          d_d     = alu_rsp.sum[TW-1:0];
          state_d = S_IX1;
        end else begin
          res_valid_d = 1'b1;
          res_d       = '{KIND_REJECT, ST_IN_ORDER, pkt_q.seq, '0, 1'b1};
          state_d     = S_IDLE;
        end
      end

      S_IX1: begin
        // Slot index before reduction
        alu_req = '{1'b0, SEQ_W'(ldix_q), SEQ_W'(d_q)};
        t_d     = alu_rsp.sum[TW-1:0];
        state_d = wrap_q ? S_IX2 : S_RED;
      end

      S_IX2: begin
        // Correct for the sequence wrap
        alu_req = '{1'b0, SEQ_W'(t_q), WrapAdj};
        t_d     = alu_rsp.sum[TW-1:0];
        state_d = S_RED;
      end

      S_RED: begin
        // Reduce below the window, then store or report the slot
        alu_req = '{1'b1, SEQ_W'(t_q), WinW};
        if (alu_rsp.carry) begin
          t_d = alu_rsp.sum[TW-1:0];
        end else begin
          slot_addr   = t_q[IXW-1:0];
          res_valid_d = 1'b1;
          if (slot_valid[t_q[IXW-1:0]]) begin
            res_d = '{KIND_ACK, ST_ALREADY_BUF, pkt_q.seq, '0, 1'b1};
          end else begin
            slot_set = 1'b1;
            res_d    = '{KIND_ACK, ST_BUFFERED, pkt_q.seq, '0, 1'b1};
          end
          state_d = S_IDLE;
        end
      end

      S_DLV: begin
        // Deliver the in-order packet, look ahead at the following slot
        nix         = ix_next(cur_ix, pkt_q.seq);
        nvalid      = slot_valid[nix];
        res_valid_d = 1'b1;
        res_d       = '{KIND_DELIVER, ST_IN_ORDER, pkt_q.seq, pkt_q.payload_tag, ~nvalid};
        ld_d        = pkt_q.seq;
        ldix_d      = cur_ix;
        cnt_d       = '0;
        if (nvalid) begin
          slot_rd      = 1'b1;
          slot_rd_addr = nix;
          state_d      = S_DRN;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_DRN: begin
        // Deliver one buffered slot and drop it
        alu_req     = '{1'b0, ld_q, SEQ_W'(1)};
        nix         = ix_next(cur_ix, alu_rsp.sum);
        nvalid      = slot_valid[nix] && (nix != cur_ix);
        lastf       = ~nvalid || (cnt_q == CntMax);
        res_valid_d = 1'b1;
        res_d       = '{KIND_DELIVER, ST_IN_ORDER, alu_rsp.sum, slot_rdata, lastf};
        slot_clr    = 1'b1;
        slot_addr   = cur_ix;
        ld_d        = alu_rsp.sum;
        ldix_d      = cur_ix;
        cnt_d       = cnt_q + 1'b1;
        if (lastf) begin
          state_d = S_IDLE;
        end else begin
          slot_rd      = 1'b1;
          slot_rd_addr = nix;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ld_q        <= {SEQ_W{1'b1}};
      ldix_q      <= LdIxReset;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ld_q        <= ld_d;
      ldix_q      <= ldix_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pkt_q  <= pkt_d;
    d_q    <= d_d;
    wrap_q <= wrap_d;
    t_q    <= t_d;
    res_q  <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // More results follow exactly when the transaction is not yet finished
  a_busy_tracks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (busy == ~res_o.last))
    else $error("busy does not match the last flag");

  // An in-order acknowledge is followed by delivery of the same number
  a_ack_then_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_ACK && res_o.status == ST_IN_ORDER && !res_o.last)
    |=> (res_valid_o && res_o.kind == KIND_DELIVER && res_o.out_seq == $past(res_o.out_seq)))
    else $error("in-order acknowledge not followed by its delivery");

  // Drained deliveries run in consecutive sequence numbers
  a_drain_in_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_DELIVER && !res_o.last)
    |=> (res_valid_o && res_o.kind == KIND_DELIVER
         && res_o.out_seq == SEQ_W'($past(res_o.out_seq) + SEQ_W'(1))))
    else $error("drain delivered out of sequence");

endmodule

`default_nettype wire
